// ===== hw/rtl/tppaf_pkg.sv =====
`default_nettype none

package tppaf_pkg;

  // Field widths
  localparam int unsigned POS_W  = 15;
  localparam int unsigned BTN_W  = 3;
  localparam int unsigned LVL_W  = 8;
  localparam int unsigned HOLD_W = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;

  // Parameter defaults
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned POS_MAX_DEF     = 32767;

  // Register reset values
  localparam logic [HOLD_W-1:0] HOLD_RST  = HOLD_W'(180);
  localparam logic [LVL_W-1:0]  X_MIN_RST = LVL_W'(16);
  localparam logic [LVL_W-1:0]  X_MAX_RST = LVL_W'(244);
  localparam logic [LVL_W-1:0]  Y_MIN_RST = LVL_W'(23);
  localparam logic [LVL_W-1:0]  Y_MAX_RST = LVL_W'(241);

  // Presented levels
  localparam logic [LVL_W-1:0] LEVEL_HIGH = LVL_W'(255);
  localparam logic [LVL_W-1:0] LEVEL_LOW  = LVL_W'(0);

  // Select line codes
  localparam logic [1:0] SEL_X    = 2'b01;
  localparam logic [1:0] SEL_Y    = 2'b10;
  localparam logic [1:0] SEL_ZERO = 2'b11;
  localparam logic [1:0] SEL_RST  = 2'b11;

  typedef enum logic [1:0] {
    MODE_POINTER = 2'd0,
    MODE_SELECT  = 2'd1,
    MODE_TICK    = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_HOLD  = 3'd0,
    REG_X_MIN = 3'd1,
    REG_X_MAX = 3'd2,
    REG_Y_MIN = 3'd3,
    REG_Y_MAX = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    OUT_IDLE = 2'd0,
    OUT_X    = 2'd1,
    OUT_Y    = 2'd2,
    OUT_ZERO = 2'd3
  } out_e;

  typedef struct packed {
    logic [HOLD_W-1:0] hold_ticks;
    logic [LVL_W-1:0]  x_min;
    logic [LVL_W-1:0]  x_max;
    logic [LVL_W-1:0]  y_min;
    logic [LVL_W-1:0]  y_max;
  } cfg_t;

  typedef struct packed {
    logic [BTN_W-1:0] buttons;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } entry_t;

  typedef struct packed {
    logic             touched;
    logic [1:0]       sel;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } view_t;

endpackage

`default_nettype wire

// ===== hw/rtl/touch_panel_paced_analog_front.sv =====
`default_nettype none

// Paced resistive touch panel front end. A transaction is taken on every
// clock edge at which start is high; busy stays low, so one transaction per
// cycle is sustained. Every transaction gives exactly one result, strobed by
// result_valid_o for a single cycle; the receiver must take it then. The
// queue, timer and select state update in the cycle of acceptance; the result
// then passes the queue's output register and the scaling pipeline behind it:
// span multiply, reciprocal multiply for the division by the position range,
// remainder of the estimate, then correction, offset and saturation.
// Configuration writes take effect at once and belong in idle periods; no
// clearing pass follows reset.
module touch_panel_paced_analog_front #(
  parameter int unsigned QUEUE_DEPTH = tppaf_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned POS_MAX     = tppaf_pkg::POS_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode_i,
  input  logic [tppaf_pkg::POS_W-1:0]   pos_x_i,
  input  logic [tppaf_pkg::POS_W-1:0]   pos_y_i,
  input  logic [tppaf_pkg::BTN_W-1:0]   buttons_i,
  input  logic                          select_index_i,
  input  logic                          select_level_i,
  output logic                          result_valid_o,
  output logic [tppaf_pkg::LVL_W-1:0]   x_level_o,
  output logic [tppaf_pkg::LVL_W-1:0]   y_level_o,
  output logic                          event_dropped_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tppaf_pkg::ADDR_W-1:0]  paddr,
  input  logic [tppaf_pkg::DATA_W-1:0]  pwdata,
  output logic [tppaf_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import tppaf_pkg::*;

  cfg_t  cfg;
  view_t view;
  logic  accept, q_valid, q_dropped;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  tppaf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tppaf_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .mode_i         (mode_e'(mode_i)),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .buttons_i      (buttons_i),
    .select_index_i (select_index_i),
    .select_level_i (select_level_i),
    .hold_ticks_i   (cfg.hold_ticks),
    .view_o         (view),
    .valid_o        (q_valid),
    .dropped_o      (q_dropped)
  );

  tppaf_scale #(
    .POS_MAX (POS_MAX)
  ) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .dropped_i (q_dropped),
    .view_i    (view),
    .cfg_i     (cfg),
    .valid_o   (result_valid_o),
    .x_level_o (x_level_o),
    .y_level_o (y_level_o),
    .dropped_o (event_dropped_o)
  );

  // Every accepted transaction yields its result after a fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 result_valid_o)
    else $error("result strobe missing five cycles after acceptance");

  // A result without a matching accepted transaction is invented
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, 5))
    else $error("result strobe without an accepted transaction");

  // Only a pointer event can be lost, and only on a result cycle
  a_drop_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_dropped_o |-> result_valid_o && $past(mode_i, 5) == MODE_POINTER)
    else $error("dropped flag on a result not caused by a pointer event");

endmodule

`default_nettype wire

// ===== hw/rtl/tppaf_regs.sv =====
`default_nettype none

module tppaf_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tppaf_pkg::ADDR_W-1:0]  paddr,
  input  logic [tppaf_pkg::DATA_W-1:0]  pwdata,
  output logic [tppaf_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output tppaf_pkg::cfg_t               cfg_o
);
  import tppaf_pkg::*;

  cfg_t cfg_q;
  reg_e idx;
  logic wr;

  assign pready = 1'b1;
  assign idx    = reg_e'(paddr[ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  // Write on the access phase of a write transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ticks <= HOLD_RST;
      cfg_q.x_min      <= X_MIN_RST;
      cfg_q.x_max      <= X_MAX_RST;
      cfg_q.y_min      <= Y_MIN_RST;
      cfg_q.y_max      <= Y_MAX_RST;
    end else if (wr) begin
      unique case (idx)
        REG_HOLD:  cfg_q.hold_ticks <= pwdata[HOLD_W-1:0];
        REG_X_MIN: cfg_q.x_min      <= pwdata[LVL_W-1:0];
        REG_X_MAX: cfg_q.x_max      <= pwdata[LVL_W-1:0];
        REG_Y_MIN: cfg_q.y_min      <= pwdata[LVL_W-1:0];
        REG_Y_MAX: cfg_q.y_max      <= pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_HOLD:  prdata = DATA_W'(cfg_q.hold_ticks);
      REG_X_MIN: prdata = DATA_W'(cfg_q.x_min);
      REG_X_MAX: prdata = DATA_W'(cfg_q.x_max);
      REG_Y_MIN: prdata = DATA_W'(cfg_q.y_min);
      REG_Y_MAX: prdata = DATA_W'(cfg_q.y_max);
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tppaf_queue.sv =====
`default_nettype none

module tppaf_queue #(
  parameter int unsigned QUEUE_DEPTH = tppaf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  tppaf_pkg::mode_e              mode_i,
  input  logic [tppaf_pkg::POS_W-1:0]   pos_x_i,
  input  logic [tppaf_pkg::POS_W-1:0]   pos_y_i,
  input  logic [tppaf_pkg::BTN_W-1:0]   buttons_i,
  input  logic                          select_index_i,
  input  logic                          select_level_i,
  input  logic [tppaf_pkg::HOLD_W-1:0]  hold_ticks_i,
  output tppaf_pkg::view_t              view_o,
  output logic                          valid_o,
  output logic                          dropped_o
);
  import tppaf_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W:0]   SUM_WRAP = (PTR_W + 1)'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  entry_t mem [QUEUE_DEPTH];

  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [HOLD_W-1:0] hold_q, hold_d;
  entry_t            touch_q, touch_d;
  logic [1:0]        sel_q, sel_d;
  logic [BTN_W-1:0]  prev_q, prev_d;
  entry_t            next_q;
  logic              valid_q, dropped_q;

  entry_t            wdata;
  logic [PTR_W:0]    tail_sum;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  next_addr;
  logic [HOLD_W-1:0] hold_load;
  logic              changed, push, drop;

  assign wdata     = '{buttons: buttons_i, pos_x: pos_x_i, pos_y: pos_y_i};
  assign tail_sum  = {1'b0, head_q} + {1'b0, count_q[PTR_W-1:0]};
  assign tail      = (tail_sum >= SUM_WRAP) ? PTR_W'(tail_sum - SUM_WRAP)
                                            : tail_sum[PTR_W-1:0];
  assign hold_load = (hold_ticks_i == '0) ? HOLD_W'(1) : hold_ticks_i;
  assign changed   = accept_i && (mode_i == MODE_POINTER) && (buttons_i != prev_q);
  assign push      = changed && (count_q != CNT_FULL);
  assign drop      = changed && (count_q == CNT_FULL);

  // Next state for one transaction
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    hold_d  = hold_q;
    touch_d = touch_q;
    sel_d   = sel_q;
    prev_d  = prev_q;
    if (accept_i) begin
      unique case (mode_i)
        MODE_POINTER: begin
          if (push) begin
            count_d = count_q + CNT_W'(1);
            prev_d  = buttons_i;
            if (count_q == '0) begin
              touch_d = wdata;
              hold_d  = hold_load;
            end
          end
        end
        MODE_SELECT: begin
          sel_d[select_index_i] = select_level_i;
        end
        MODE_TICK: begin
          if (hold_q != '0) begin
            hold_d = hold_q - HOLD_W'(1);
            if (hold_q == HOLD_W'(1) && count_q != '0) begin
              head_d  = ptr_inc(head_q);
              count_d = count_q - CNT_W'(1);
              if (count_q != CNT_W'(1)) begin
                touch_d = next_q;
                hold_d  = hold_load;
              end
            end
          end
        end
        MODE_NOP: ;
      endcase
    end
  end

  assign next_addr = ptr_inc(head_d);

  // Hold the queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      hold_q    <= '0;
      touch_q   <= '0;
      sel_q     <= SEL_RST;
      prev_q    <= '0;
      valid_q   <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      count_q   <= count_d;
      hold_q    <= hold_d;
      touch_q   <= touch_d;
      sel_q     <= sel_d;
      prev_q    <= prev_d;
      valid_q   <= accept_i;
      dropped_q <= drop;
    end
  end

  // Event storage; keep the entry after the head ready, bypassing a same-cycle write
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[tail] <= wdata;
    end
    next_q <= (push && tail == next_addr) ? wdata : mem[next_addr];
  end

  assign view_o    = '{touched: (touch_q.buttons != '0), sel: sel_q,
                       pos_x: touch_q.pos_x, pos_y: touch_q.pos_y};
  assign valid_o   = valid_q;
  assign dropped_o = dropped_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tppaf_scale.sv =====
`default_nettype none

module tppaf_scale #(
  parameter int unsigned POS_MAX = tppaf_pkg::POS_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic                         dropped_i,
  input  tppaf_pkg::view_t             view_i,
  input  tppaf_pkg::cfg_t              cfg_i,
  output logic                         valid_o,
  output logic [tppaf_pkg::LVL_W-1:0]  x_level_o,
  output logic [tppaf_pkg::LVL_W-1:0]  y_level_o,
  output logic                         dropped_o
);
  import tppaf_pkg::*;

  localparam int unsigned ABS_W  = POS_W + LVL_W;
  localparam int unsigned PW     = $clog2(POS_MAX + 1);
  localparam int unsigned MUL1_W = 2 * ABS_W + 1;
  localparam int unsigned MUL2_W = ABS_W + PW;
  localparam int unsigned SUM_W  = ABS_W + 3;
  localparam logic [ABS_W:0]  RECIP = (ABS_W + 1)'((64'd1 << ABS_W) / POS_MAX);
  localparam logic [PW-1:0]   DIV   = PW'(POS_MAX);

  // Stage 0: choose the channel
  out_e             kind;
  logic [POS_W-1:0] pos;
  logic [LVL_W-1:0] lo, hi, mag;
  logic             neg;

  always_comb begin
    if (!view_i.touched) begin
      kind = OUT_IDLE;
    end else begin
      unique case (view_i.sel)
        SEL_X:    kind = OUT_X;
        SEL_Y:    kind = OUT_Y;
        SEL_ZERO: kind = OUT_ZERO;
        default:  kind = OUT_IDLE;
      endcase
    end
  end

  assign pos = (kind == OUT_Y) ? view_i.pos_y : view_i.pos_x;
  assign lo  = (kind == OUT_Y) ? cfg_i.y_min : cfg_i.x_min;
  assign hi  = (kind == OUT_Y) ? cfg_i.y_max : cfg_i.x_max;
  assign neg = hi < lo;
  assign mag = neg ? (lo - hi) : (hi - lo);

  // Stage 1: position times span magnitude
  logic             s1_valid_q, s1_dropped_q, s1_neg_q;
  out_e             s1_kind_q;
  logic [LVL_W-1:0] s1_lo_q;
  logic [ABS_W-1:0] s1_pmag_q;

  // Stage 2: quotient estimate by reciprocal
  logic             s2_valid_q, s2_dropped_q, s2_neg_q;
  out_e             s2_kind_q;
  logic [LVL_W-1:0] s2_lo_q;
  logic [ABS_W-1:0] s2_pmag_q, s2_qe_q;
  logic [MUL1_W-1:0] qprod;

  // Stage 3: remainder of the estimate
  logic             s3_valid_q, s3_dropped_q, s3_neg_q;
  out_e             s3_kind_q;
  logic [LVL_W-1:0] s3_lo_q;
  logic [ABS_W-1:0] s3_qe_q;
  logic [PW:0]      s3_rem_q;
  logic [MUL2_W-1:0] back, rem_full;

  // Stage 4: correct, offset, saturate
  logic                    out_valid_q, out_dropped_q;
  logic [LVL_W-1:0]        x_q, y_q;
  logic [ABS_W:0]          quot;
  logic signed [SUM_W-1:0] lo_ext, q_ext, sum;
  logic [LVL_W-1:0]        sat, x_d, y_d;

  assign qprod    = MUL1_W'(s1_pmag_q) * MUL1_W'(RECIP);
  assign back     = MUL2_W'(s2_qe_q) * MUL2_W'(DIV);
  assign rem_full = MUL2_W'(s2_pmag_q) - back;

  assign quot   = (ABS_W + 1)'(s3_qe_q) + (ABS_W + 1)'(s3_rem_q >= {1'b0, DIV});
  assign lo_ext = $signed(SUM_W'(s3_lo_q));
  assign q_ext  = $signed(SUM_W'(quot));
  assign sum    = s3_neg_q ? (lo_ext - q_ext) : (lo_ext + q_ext);

  always_comb begin
    if (sum < 0) begin
      sat = LEVEL_LOW;
    end else if (sum > $signed(SUM_W'(LEVEL_HIGH))) begin
      sat = LEVEL_HIGH;
    end else begin
      sat = sum[LVL_W-1:0];
    end
  end

  always_comb begin
    x_d = LEVEL_HIGH;
    y_d = LEVEL_HIGH;
    unique case (s3_kind_q)
      OUT_IDLE: ;
      OUT_X:    x_d = sat;
      OUT_Y:    y_d = sat;
      OUT_ZERO: x_d = LEVEL_LOW;
    endcase
  end

  // Advance the control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      s3_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      out_dropped_q <= 1'b0;
    end else begin
      s1_valid_q    <= valid_i;
      s2_valid_q    <= s1_valid_q;
      s3_valid_q    <= s2_valid_q;
      out_valid_q   <= s3_valid_q;
      out_dropped_q <= s3_valid_q & s3_dropped_q;
    end
  end

  // Advance the data
  always_ff @(posedge clk_i) begin
    s1_dropped_q <= dropped_i;
    s1_neg_q     <= neg;
    s1_kind_q    <= kind;
    s1_lo_q      <= lo;
    s1_pmag_q    <= ABS_W'(pos) * ABS_W'(mag);

    s2_dropped_q <= s1_dropped_q;
    s2_neg_q     <= s1_neg_q;
    s2_kind_q    <= s1_kind_q;
    s2_lo_q      <= s1_lo_q;
    s2_pmag_q    <= s1_pmag_q;
    s2_qe_q      <= qprod[ABS_W +: ABS_W];

    s3_dropped_q <= s2_dropped_q;
    s3_neg_q     <= s2_neg_q;
    s3_kind_q    <= s2_kind_q;
    s3_lo_q      <= s2_lo_q;
    s3_qe_q      <= s2_qe_q;
    s3_rem_q     <= rem_full[PW:0];

    x_q          <= x_d;
    y_q          <= y_d;
  end

  assign valid_o   = out_valid_q;
  assign x_level_o = x_q;
  assign y_level_o = y_q;
  assign dropped_o = out_dropped_q;

endmodule

`default_nettype wire
